FILE: sv/wsds_pkg.sv
`default_nettype none

package wsds_pkg;

   // Width of the running byte position inside one image.
   localparam int POS_BITS = 32;

   localparam int PREAMBLE_BYTES = 8;
   localparam logic [7:0] MAX_ID = 8'd12;
   localparam logic [30:0] LEN_LIMIT = 31'h7FFF_FFFF;

   // The length decoder counts 7-bit groups and stops counting after ten.
   localparam logic [3:0] GROUP_CAP = 4'd10;

   typedef logic [POS_BITS-1:0] pos_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_SHORT    = 3'd1,
      ERR_TRUNC    = 3'd2,
      ERR_OVERFLOW = 3'd3,
      ERR_ID       = 3'd4
   } err_type;

   typedef enum logic {
      KIND_ENTRY = 1'b0,
      KIND_ERROR = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      PH_PREAMBLE = 4'b0001,
      PH_ID       = 4'b0010,
      PH_LEN      = 4'b0100,
      PH_SKIP     = 4'b1000
   } phase_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  section_id;
      logic [31:0] content_offset;
      logic [30:0] content_length;
      err_type     error_code;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/wsds_if.sv
`default_nettype none

interface wsds_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_end;

   modport source (output valid, output data_byte, output image_end, input ready);
   modport sink (input valid, input data_byte, input image_end, output ready);
endinterface

interface wsds_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  section_id;
   logic [31:0] content_offset;
   logic [30:0] content_length;
   logic [2:0]  error_code;

   modport source (output valid, output result_kind, output section_id,
                   output content_offset, output content_length, output error_code,
                   input ready);
   modport sink (input valid, input result_kind, input section_id,
                 input content_offset, input content_length, input error_code,
                 output ready);
endinterface

`default_nettype wire

FILE: sv/wasm_section_directory_scanner.sv
// WebAssembly section header scanner.
// The req_ch channel carries one image byte per transaction, with image_end
// set on the final byte. The first eight bytes (magic and version) are
// skipped. Each section header (id byte plus unsigned LEB128 length) produces
// one transaction on rsp_ch: a section entry with id, content offset and
// length, or an error report. After an error, bytes are dropped silently
// until image_end, and every image_end returns the scanner to its start.
// Each byte is processed in the cycle it is accepted, and its result enters a
// two-entry result queue; the result is registered there before it shows on
// rsp_ch. Throughput is one byte per cycle as long as the receiver keeps up;
// the result queue is what limits it.
// When the receiver stalls, bytes keep flowing until both queue entries hold
// results, then req_ch.ready drops until an entry is taken.
// Reset (synchronous, active high) empties the queue and puts the scanner in
// the preamble phase at byte position zero.
`default_nettype none

module wasm_section_directory_scanner
   import wsds_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   wsds_req_if.sink  req_ch,
   wsds_rsp_if.source rsp_ch
);

   // Scanner state.
   phase_type   phase_ff, phase_in;
   pos_type     pos_ff, pos_in;
   logic [30:0] len_low_ff, len_low_in;   // low 31 bits of the decoded length
   logic        len_high_ff, len_high_in; // some bit at 31 or above is set
   logic [3:0]  group_ff, group_in;       // 7-bit groups seen, capped
   logic [7:0]  id_ff, id_in;
   logic [31:0] skip_ff, skip_in;
   logic        failed_ff, failed_in;

   logic        accept;
   logic        fifo_room;
   logic        res_valid;
   rsp_type     res;
   logic        head_valid;
   rsp_type     head;

   logic [7:0]  byte_in;
   logic        last;
   logic [6:0]  chunk;
   logic [30:0] low_next;
   logic        high_next;
   pos_type     pos_plus;

   assign byte_in = req_ch.data_byte;
   assign last    = req_ch.image_end;
   assign chunk   = byte_in[6:0];
   assign pos_plus = pos_ff + pos_type'(1);

   assign req_ch.ready = fifo_room;
   assign accept = req_ch.valid && fifo_room;

   // Fold the current 7-bit group into the length. Only 31 low bits are kept;
   // anything landing at bit 31 or higher just marks the length as too large.
   // Groups past bit 63 are dropped entirely.
   always_comb begin
      low_next  = len_low_ff;
      high_next = len_high_ff;
      case (group_ff)
         4'd0: low_next = len_low_ff | {24'd0, chunk};
         4'd1: low_next = len_low_ff | {17'd0, chunk, 7'd0};
         4'd2: low_next = len_low_ff | {10'd0, chunk, 14'd0};
         4'd3: low_next = len_low_ff | {3'd0, chunk, 21'd0};
         4'd4: begin
            low_next  = len_low_ff | {chunk[2:0], 28'd0};
            high_next = len_high_ff | (|chunk[6:3]);
         end
         4'd5, 4'd6, 4'd7, 4'd8: high_next = len_high_ff | (|chunk);
         4'd9: high_next = len_high_ff | chunk[0];
         default: high_next = len_high_ff;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_plus;
      len_low_in  = len_low_ff;
      len_high_in = len_high_ff;
      group_in    = group_ff;
      id_in       = id_ff;
      skip_in     = skip_ff;
      failed_in   = failed_ff;
      res_valid   = 1'b0;
      res         = '{result_kind: KIND_ERROR, section_id: 8'd0, content_offset: 32'd0,
                      content_length: 31'd0, error_code: ERR_NONE};

      if (!failed_ff) begin
         case (phase_ff)
            PH_PREAMBLE: begin
               if (pos_ff >= pos_type'(PREAMBLE_BYTES - 1)) begin
                  phase_in = PH_ID;
               end else if (last) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_SHORT;
               end
            end
            PH_ID: begin
               id_in       = byte_in;
               len_low_in  = 31'd0;
               len_high_in = 1'b0;
               group_in    = 4'd0;
               phase_in    = PH_LEN;
               if (last) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_TRUNC;
               end
            end
            PH_LEN: begin
               len_low_in  = low_next;
               len_high_in = high_next;
               group_in    = (group_ff == GROUP_CAP) ? GROUP_CAP : group_ff + 4'd1;
               if (byte_in[7]) begin
                  if (last) begin
                     res_valid      = 1'b1;
                     res.error_code = ERR_TRUNC;
                  end
               end else if (high_next || low_next == LEN_LIMIT) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_OVERFLOW;
               end else if (id_ff > MAX_ID) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_ID;
               end else begin
                  res_valid          = 1'b1;
                  res.result_kind    = KIND_ENTRY;
                  res.section_id     = id_ff;
                  res.content_offset = 32'(pos_plus);
                  res.content_length = low_next;
                  skip_in            = {1'b0, low_next};
                  phase_in           = (low_next != 31'd0) ? PH_SKIP : PH_ID;
               end
            end
            PH_SKIP: begin
               // The count is never zero in this phase.
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_in = PH_ID;
               end
            end
            default: phase_in = PH_PREAMBLE;
         endcase
         if (res_valid && res.result_kind == KIND_ERROR) begin
            failed_in = 1'b1;
         end
      end

      // The final byte of an image always restarts the scanner.
      if (last) begin
         phase_in    = PH_PREAMBLE;
         pos_in      = '0;
         len_low_in  = 31'd0;
         len_high_in = 1'b0;
         group_in    = 4'd0;
         id_in       = 8'd0;
         skip_in     = 32'd0;
         failed_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PREAMBLE;
         pos_ff      <= '0;
         len_low_ff  <= 31'd0;
         len_high_ff <= 1'b0;
         group_ff    <= 4'd0;
         id_ff       <= 8'd0;
         skip_ff     <= 32'd0;
         failed_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         len_low_ff  <= len_low_in;
         len_high_ff <= len_high_in;
         group_ff    <= group_in;
         id_ff       <= id_in;
         skip_ff     <= skip_in;
         failed_ff   <= failed_in;
      end
   end

   wsds_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && res_valid),
      .push_data  (res),
      .has_room   (fifo_room),
      .head_valid (head_valid),
      .head_data  (head),
      .pop        (rsp_ch.ready)
   );

   assign rsp_ch.valid          = head_valid;
   assign rsp_ch.result_kind    = head.result_kind;
   assign rsp_ch.section_id     = head.section_id;
   assign rsp_ch.content_offset = head.content_offset;
   assign rsp_ch.content_length = head.content_length;
   assign rsp_ch.error_code     = head.error_code;

endmodule

`default_nettype wire

FILE: sv/wsds_rsp_fifo.sv
`default_nettype none

// Two-entry result queue; the head entry drives the output directly.
module wsds_rsp_fifo
   import wsds_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         has_room,
   output logic         head_valid,
   output rsp_type      head_data,
   input  wire logic    pop
);

   rsp_type     entry_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        do_pop;

   assign has_room   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb_wasm_section_directory_scanner.sv
`default_nettype none

module tb_wasm_section_directory_scanner;
   import wsds_pkg::*;

   // One row of the directed stimulus. When typed is set, has_rsp and rsp give
   // the result written by hand; otherwise the scan predictor decides.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic       has_rsp;
      rsp_type    rsp;
   } scan_row_type;

   localparam rsp_type NO_RSP = '0;

   // Directed part, three images back to back.
   // The first is a single 0xFF byte that is also the final one, so the
   // preamble is cut short. The second has a real magic and version, an empty
   // section with id 0 whose content starts at position 10, a header with
   // id 13 (unknown id) and then bytes that must be ignored until the final
   // byte. The third is 0xFF bytes and ends on a 0x80 length byte, whose
   // continuation bit is set, so the header is truncated.
   localparam scan_row_type DIRECTED [25] = '{
      '{8'hFF, 1'b1, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 32'd0, 31'd0, ERR_SHORT}},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h61, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h73, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h6D, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{KIND_ENTRY, 8'h00, 32'd10, 31'd0, ERR_NONE}},
      '{8'h0D, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 32'd0, 31'd0, ERR_ID}},
      '{8'h55, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h80, 1'b1, 1'b1, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h80, 1'b1, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 32'd0, 31'd0, ERR_TRUNC}}
   };

   logic clock;
   logic reset;

   wsds_req_if req_ch ();
   wsds_rsp_if rsp_ch ();

   wasm_section_directory_scanner dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Results still owed by the scanner, oldest first.
   rsp_type awaited_headers[$];
   int      mismatch_count = 0;

   // Bytes that were accepted while the scanner was not in its sticky error
   // state; this is what the random part counts toward its length.
   int      live_items = 0;

   // Sender burst bookkeeping.
   int      burst_left = 0;

   // Image under construction in the random part.
   logic [7:0] image_bytes[$];

   // The scan predictor keeps its own copy of the scanner state.
   phase_type   phase_now = PH_PREAMBLE;
   pos_type     byte_pos = '0;
   logic [63:0] len_acc = '0;
   logic [6:0]  len_shift = '0;
   logic [7:0]  hdr_id = '0;
   logic [31:0] skip_left = '0;
   bit          stuck = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void clear_scan();
      phase_now = PH_PREAMBLE;
      byte_pos = '0;
      len_acc = '0;
      len_shift = '0;
      hdr_id = '0;
      skip_left = '0;
      stuck = 1'b0;
   endfunction

   function automatic rsp_type error_rsp(err_type code);
      rsp_type r;
      r = '0;
      r.result_kind = KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

   // Advances the predicted scanner by one byte. Returns 1 when the byte
   // produces a result, which is then placed in r.
   function automatic bit scan_byte(input logic [7:0] b, input bit last,
                                    output rsp_type r);
      pos_type here;
      bit      hit;
      here = byte_pos;
      hit = 1'b0;
      r = '0;
      byte_pos = here + 1'b1;
      if (!stuck) begin
         case (phase_now)
            PH_PREAMBLE: begin
               // Magic and version are skipped without any check.
               if (here >= pos_type'(PREAMBLE_BYTES - 1)) begin
                  phase_now = PH_ID;
               end else if (last) begin
                  r = error_rsp(ERR_SHORT);
                  hit = 1'b1;
               end
            end
            PH_ID: begin
               hdr_id = b;
               len_acc = '0;
               len_shift = '0;
               phase_now = PH_LEN;
               if (last) begin
                  r = error_rsp(ERR_TRUNC);
                  hit = 1'b1;
               end
            end
            PH_LEN: begin
               // Payload groups that start at bit 64 or above are dropped, and
               // the shift stops growing at 70.
               if (len_shift < 7'd64) begin
                  len_acc |= {57'd0, b[6:0]} << len_shift;
               end
               len_shift = (len_shift > 7'd63) ? 7'd70 : len_shift + 7'd7;
               if (b[7]) begin
                  if (last) begin
                     r = error_rsp(ERR_TRUNC);
                     hit = 1'b1;
                  end
               end else if (len_acc >= {33'd0, LEN_LIMIT}) begin
                  r = error_rsp(ERR_OVERFLOW);
                  hit = 1'b1;
               end else if (hdr_id > MAX_ID) begin
                  r = error_rsp(ERR_ID);
                  hit = 1'b1;
               end else begin
                  r.result_kind = KIND_ENTRY;
                  r.section_id = hdr_id;
                  r.content_offset = 32'(byte_pos);
                  r.content_length = len_acc[30:0];
                  r.error_code = ERR_NONE;
                  hit = 1'b1;
                  skip_left = len_acc[31:0];
                  phase_now = (skip_left != 0) ? PH_SKIP : PH_ID;
               end
            end
            default: begin
               if (skip_left != 0) begin
                  skip_left--;
               end
               if (skip_left == 0) begin
                  phase_now = PH_ID;
               end
            end
         endcase
      end
      // An error report makes the scanner deaf until the final byte.
      if (hit && r.result_kind == KIND_ERROR) begin
         stuck = 1'b1;
      end
      if (last) begin
         clear_scan();
      end
      return hit;
   endfunction

   // Appends an unsigned LEB128 encoding of value to the image, followed by
   // pad redundant groups, so that long encodings of small values occur.
   task automatic push_leb(input logic [63:0] value, input int pad);
      logic [63:0] v;
      logic [6:0]  g;
      int          extra;
      v = value;
      extra = pad;
      forever begin
         g = v[6:0];
         v = v >> 7;
         if (v != 0 || extra > 0) begin
            if (v == 0) begin
               extra--;
            end
            image_bytes.push_back({1'b1, g});
         end else begin
            image_bytes.push_back({1'b0, g});
            break;
         end
      end
   endtask

   // Presents one byte on req_ch and waits for its transaction. The sender
   // works in bursts; at the start of each burst it may idle for a while.
   // After the transaction the predictor is stepped, and the expected result,
   // if any, is queued.
   task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                            input bit has_rsp, input rsp_type want);
      int      gap;
      bit      hit;
      bit      was_stuck;
      rsp_type pred;
      gap = 0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      @(negedge clock);
      for (int k = 0; k < gap; k++) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.image_end <= last;
      do @(posedge clock); while (!req_ch.ready);
      was_stuck = stuck;
      hit = scan_byte(b, last, pred);
      if (typed) begin
         if (has_rsp) begin
            awaited_headers.push_back(want);
         end
      end else if (hit) begin
         awaited_headers.push_back(pred);
      end
      if (!was_stuck) begin
         live_items++;
      end
   endtask

   // Drops valid and waits until the scanner has delivered every result it
   // owes.
   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited_headers.size() != 0) @(posedge clock);
   endtask

   // Receiver: ready follows a pattern that switches at random between modes:
   // no stalls at all, frequent short stalls, or rare long ones.
   initial begin : rsp_ready_pattern
      int mode;
      int mode_left;
      int stall_left;
      mode = 0;
      mode_left = 0;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 250);
         end
         mode_left--;
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (mode == 1 && $urandom_range(0, 2) == 0) begin
               stall_left = $urandom_range(1, 3);
            end else if (mode == 2 && $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(5, 20);
            end
         end
      end
   end

   // Result checker: every rsp_ch transaction is compared, field by field,
   // with the oldest expected result.
   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.result_kind, rsp_ch.section_id, rsp_ch.content_offset,
                rsp_ch.content_length, rsp_ch.error_code};
         if (awaited_headers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = awaited_headers.pop_front();
            if (got.result_kind !== want.result_kind) begin
               $display("%0t: result_kind expected %0d actual %0d", $time,
                        want.result_kind, got.result_kind);
               mismatch_count++;
            end
            if (got.section_id !== want.section_id) begin
               $display("%0t: section_id expected %0d actual %0d", $time,
                        want.section_id, got.section_id);
               mismatch_count++;
            end
            if (got.content_offset !== want.content_offset) begin
               $display("%0t: content_offset expected %0d actual %0d", $time,
                        want.content_offset, got.content_offset);
               mismatch_count++;
            end
            if (got.content_length !== want.content_length) begin
               $display("%0t: content_length expected %0d actual %0d", $time,
                        want.content_length, got.content_length);
               mismatch_count++;
            end
            if (got.error_code !== want.error_code) begin
               $display("%0t: error_code expected %0d actual %0d", $time,
                        want.error_code, got.error_code);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int          flavor;
      int          nsec;
      int          bad_at;
      int          fault;
      int          pick;
      logic [63:0] len;
      bit          paused;
      paused = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.image_end <= 1'b0;
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED); i++) begin
         send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed,
                   DIRECTED[i].has_rsp, DIRECTED[i].rsp);
      end
      hold_until_drained();

      // Random images. Most are well formed with random content: a preamble
      // of random bytes, a few sections, sometimes with padded length
      // encodings. The rest are pure noise, short images, images whose last
      // section runs past the end, and images that go wrong at a random
      // header: truncated id, truncated length, length overflow, unknown id,
      // or an overlong length encoding. Bytes after an error keep coming
      // until the final byte, which checks that the error state is sticky.
      while (live_items < 1900) begin
         image_bytes.delete();
         flavor = $urandom_range(0, 19);
         if (flavor == 0) begin
            repeat ($urandom_range(1, 12)) image_bytes.push_back(8'($urandom));
         end else if (flavor == 1) begin
            repeat ($urandom_range(1, 7)) image_bytes.push_back(8'($urandom));
         end else begin
            repeat (8) image_bytes.push_back(8'($urandom));
            nsec = $urandom_range(0, 5);
            bad_at = (flavor >= 3 && flavor <= 6) ? $urandom_range(0, nsec) : -1;
            for (int s = 0; s <= nsec; s++) begin
               if (s == bad_at) begin
                  fault = $urandom_range(0, 4);
                  case (fault)
                     0: image_bytes.push_back(8'($urandom));
                     1: begin
                        image_bytes.push_back(8'($urandom));
                        repeat ($urandom_range(1, 4)) begin
                           image_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                        end
                     end
                     2: begin
                        image_bytes.push_back(8'($urandom));
                        pick = $urandom_range(0, 3);
                        if (pick == 0) begin
                           len = 64'd2147483647;
                        end else if (pick == 1) begin
                           len = 64'd2147483648;
                        end else if (pick == 2) begin
                           len = {32'($urandom), 32'($urandom)} | 64'h8000_0000;
                        end else begin
                           len = {32'd0, 32'($urandom)} | 64'h7FFF_FFFF;
                        end
                        push_leb(len, $urandom_range(0, 2));
                     end
                     3: begin
                        image_bytes.push_back(8'($urandom_range(13, 255)));
                        push_leb(64'($urandom_range(0, 8)), 0);
                     end
                     default: begin
                        // Ten or more groups: the shift saturates and high
                        // payload bits fall away. With zero payloads the
                        // header is still a valid empty section.
                        pick = $urandom_range(0, 1);
                        image_bytes.push_back(8'($urandom_range(0, 12)));
                        repeat ($urandom_range(9, 13)) begin
                           image_bytes.push_back(pick ? 8'h80
                                                      : 8'h80 | 8'($urandom_range(0, 127)));
                        end
                        image_bytes.push_back(pick ? 8'h00 : 8'($urandom_range(0, 127)));
                     end
                  endcase
                  if (fault >= 2) begin
                     repeat ($urandom_range(0, 6)) image_bytes.push_back(8'($urandom));
                  end
                  break;
               end
               if (s == nsec) begin
                  break;
               end
               pick = $urandom_range(0, 19);
               if (pick < 14) begin
                  len = 64'($urandom_range(0, 8));
               end else if (pick < 19) begin
                  len = 64'($urandom_range(9, 40));
               end else begin
                  len = 64'($urandom_range(41, 200));
               end
               image_bytes.push_back(8'($urandom_range(0, 12)));
               push_leb(len, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0);
               repeat (int'(len)) image_bytes.push_back(8'($urandom));
            end
            // A last section that declares far more content than follows.
            if (flavor == 2) begin
               image_bytes.push_back(8'($urandom_range(0, 12)));
               len = ($urandom_range(0, 3) == 0) ? 64'd2147483646
                                                 : 64'($urandom_range(41, 2147483646));
               push_leb(len, 0);
               repeat ($urandom_range(0, 10)) image_bytes.push_back(8'($urandom));
            end
         end
         foreach (image_bytes[i]) begin
            send_byte(image_bytes[i], i == image_bytes.size() - 1, 1'b0, 1'b0, NO_RSP);
         end
         // Halfway through, the sender holds off until the scanner has
         // caught up completely.
         if (!paused && live_items >= 950) begin
            hold_until_drained();
            paused = 1'b1;
         end
      end

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && awaited_headers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(12 * 400000);
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
sv/wsds_pkg.sv
sv/wsds_if.sv
sv/wsds_rsp_fifo.sv
sv/wasm_section_directory_scanner.sv
tb/sv/tb_wasm_section_directory_scanner.sv
